### hdl/dibw_pkg.sv
// ----------------------------------------------------------------------------
// dibw_pkg
// Shared types, command codes and conversion helpers for the bitwise ALU.
// ----------------------------------------------------------------------------
`default_nettype none
package dibw_pkg;

  typedef enum logic [2:0] {
    CMD_AND = 3'd0,
    CMD_OR  = 3'd1,
    CMD_XOR = 3'd2,
    CMD_NOT = 3'd3,
    CMD_SHL = 3'd4,
    CMD_SAR = 3'd5,
    CMD_SHR = 3'd6,
    CMD_NOP = 3'd7
  } cmd_t;

  localparam logic [10:0] EXP_MAX  = 11'h7FF;
  localparam logic [10:0] EXP_BIAS = 11'd1023;
  localparam logic [10:0] EXP_INT  = 11'd1075;

  // Truncate a double toward zero and wrap modulo 2^32.
  function automatic logic [31:0] dbl_to_u32(input logic [63:0] bits);
    logic [10:0] expo;
    logic [52:0] mant;
    logic [84:0] wide;
    logic [10:0] sh;
    logic [31:0] mag;
    expo = bits[62:52];
    mant = {1'b1, bits[51:0]};
    mag  = '0;
    if (expo != EXP_MAX && expo >= EXP_BIAS) begin
      if (expo >= EXP_INT) begin
        sh = expo - EXP_INT;
        if (sh < 11'd32) begin
          wide = {32'd0, mant} << sh[4:0];
          mag  = wide[31:0];
        end
      end else begin
        sh   = EXP_INT - expo;
        wide = {32'd0, mant} >> sh[5:0];
        mag  = wide[31:0];
      end
    end
    if (bits[63]) mag = 32'd0 - mag;
    return mag;
  endfunction

  // Exact double of a 33-bit magnitude with a sign; zero gives +0.
  function automatic logic [63:0] mag_to_dbl(input logic neg, input logic [32:0] mag);
    logic [5:0]  lz;
    logic [32:0] norm;
    logic [10:0] expo;
    lz = 6'd0;
    for (int i = 0; i < 33; i++) begin
      if (mag[i]) lz = 6'(32 - i);
    end
    norm = mag << lz;
    expo = EXP_BIAS + 11'd32 - 11'(lz);
    if (mag == 33'd0) return 64'd0;
    return {neg, expo, norm[31:0], 20'd0};
  endfunction

endpackage
`default_nettype wire

### hdl/double_int32_wrap_bitwise_alu_core.sv
// ----------------------------------------------------------------------------
// double_int32_wrap_bitwise_alu_core
// Throughput 1 transaction per cycle while the output is not stalled.
// Stage 1 converts operands, stage 2 applies the operation, stage 3 packs
// the exact double. A stall holds all stages in place.
// Synchronous active-high reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none
module double_int32_wrap_bitwise_alu_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  command,
  input  wire logic [63:0] operand_a,
  input  wire logic [63:0] operand_b,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      result_double,
  output logic [31:0]      result_word,
  output logic             result_unsigned
);
  import dibw_pkg::*;

  logic        v1, v2, v3;
  cmd_t        cmd1;
  logic [31:0] a1, b1;
  logic [31:0] r2;
  logic        uns2, ok2;
  logic [31:0] r2_next;
  logic        uns2_next, ok2_next;
  logic        adv;

  assign adv      = !(v3 && out_stall);
  assign in_stall = !adv;

  always_comb begin
    r2_next   = '0;
    uns2_next = 1'b0;
    ok2_next  = 1'b1;
    case (cmd1)
      CMD_AND: r2_next = a1 & b1;
      CMD_OR:  r2_next = a1 | b1;
      CMD_XOR: r2_next = a1 ^ b1;
      CMD_NOT: r2_next = ~a1;
      CMD_SHL: r2_next = a1 << b1[4:0];
      CMD_SAR: r2_next = $unsigned($signed(a1) >>> b1[4:0]);
      CMD_SHR: begin
        r2_next   = a1 >> b1[4:0];
        uns2_next = 1'b1;
      end
      default: ok2_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
    if (adv) begin
      cmd1            <= cmd_t'(command);
      a1              <= dbl_to_u32(operand_a);
      b1              <= dbl_to_u32(operand_b);
      r2              <= r2_next;
      uns2            <= uns2_next;
      ok2             <= ok2_next;
      result_word     <= r2;
      result_unsigned <= uns2;
      if (!ok2) begin
        result_double <= 64'd0;
      end else if (uns2 || !r2[31]) begin
        result_double <= mag_to_dbl(1'b0, {1'b0, r2});
      end else begin
        result_double <= mag_to_dbl(1'b1, 33'h1_0000_0000 - {1'b0, r2});
      end
    end
  end

  assign out_valid = v3;

endmodule
`default_nettype wire

### hdl/dibw_checker.sv
// ----------------------------------------------------------------------------
// dibw_checker
// Port-level checks on the bitwise ALU, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module dibw_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] result_double,
  input wire logic [31:0] result_word,
  input wire logic        result_unsigned
);
  a_stall_map: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall)) else $error("stall mismatch");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_word))
    else $error("output not held");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_word == 32'd0 |-> result_double == 64'd0)
    else $error("zero not +0");
  a_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_unsigned |-> !result_double[63])
    else $error("unsigned result negative");
endmodule

bind double_int32_wrap_bitwise_alu_core dibw_checker u_dibw_checker (.*);
`default_nettype wire

### dv/tb_double_int32_wrap_bitwise_alu_core.sv
// ----------------------------------------------------------------------------
// tb_double_int32_wrap_bitwise_alu_core
// Self-checking bench for the double-operand bitwise ALU. A directed table
// covers the special operands and every command. A random phase follows,
// with idle gaps on both channels and one long output hold-off. Each output
// transaction is checked in order against the table or a local predictor.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_double_int32_wrap_bitwise_alu_core;
  import dibw_pkg::*;

  localparam int NUM_RANDOM = 1730;

  typedef struct {
    cmd_t        cmd;
    logic [63:0] a;
    logic [63:0] b;
    bit          typed;
    logic [63:0] dbl;
    logic [31:0] word;
    logic        uns;
  } alu_row_t;

  typedef struct {
    logic [63:0] dbl;
    logic [31:0] word;
    logic        uns;
  } alu_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  command = '0;
  logic [63:0] operand_a = '0;
  logic [63:0] operand_b = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] result_double;
  logic [31:0] result_word;
  logic        result_unsigned;

  alu_result_t pending_results[$];
  int          errors = 0;
  int          sent = 0;
  int          checked = 0;
  int          out_wait = 0;
  bit          quiet = 1'b0;
  bit          hold_off = 1'b0;
  alu_row_t    table_rows[$];

  double_int32_wrap_bitwise_alu_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_double(result_double), .result_word(result_word),
    .result_unsigned(result_unsigned)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [31:0] trunc_wrap32(input logic [63:0] bits);
    int          e;
    logic [63:0] m;
    logic [31:0] mag;
    e = int'(bits[62:52]);
    m = {11'd0, 1'b1, bits[51:0]};
    if (e == 2047 || e < 1023) return 32'd0;
    if (e >= 1075 + 32) mag = 32'd0;
    else if (e >= 1075) mag = 32'(m << (e - 1075));
    else mag = 32'(m >> (1075 - e));
    return bits[63] ? -mag : mag;
  endfunction

  function automatic logic [63:0] word_as_double(input logic [31:0] w, input logic uns);
    longint v;
    v = uns ? longint'({32'd0, w}) : longint'($signed(w));
    return $realtobits(real'(v));
  endfunction

  function automatic alu_result_t alu_predict(input cmd_t cmd, input logic [63:0] a_bits,
                                              input logic [63:0] b_bits);
    logic [31:0] a;
    logic [31:0] b;
    logic [4:0]  cnt;
    alu_result_t r;
    a = trunc_wrap32(a_bits);
    b = trunc_wrap32(b_bits);
    cnt = b[4:0];
    r.uns = 1'b0;
    case (cmd)
      CMD_AND: r.word = a & b;
      CMD_OR:  r.word = a | b;
      CMD_XOR: r.word = a ^ b;
      CMD_NOT: r.word = ~a;
      CMD_SHL: r.word = a << cnt;
      CMD_SAR: r.word = $unsigned($signed(a) >>> cnt);
      CMD_SHR: begin
        r.word = a >> cnt;
        r.uns = 1'b1;
      end
      default: r.word = 32'd0;
    endcase
    r.dbl = (cmd == CMD_NOP) ? 64'd0 : word_as_double(r.word, r.uns);
    return r;
  endfunction

  function automatic logic [63:0] random_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1: ;
      2, 3, 4, 5: v[62:52] = 11'($urandom_range(1023, 1110));
      6: v[62:52] = 11'($urandom_range(1023, 1054));
      7: v = $realtobits(real'($signed(32'($urandom_range(0, 40)))));
      8: v[62:52] = 11'h7FF;
      default: v[62:52] = 11'($urandom_range(0, 1022));
    endcase
    return v;
  endfunction

  function automatic alu_row_t row(input cmd_t c, input logic [63:0] a, input logic [63:0] b,
                                   input bit typed = 0, input logic [63:0] dbl = 0,
                                   input logic [31:0] word = 0, input logic uns = 0);
    alu_row_t r;
    r = '{c, a, b, typed, dbl, word, uns};
    return r;
  endfunction

  task automatic send(input alu_row_t r);
    int          gap;
    alu_result_t exp_r;
    gap = (quiet || hold_off) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= r.cmd;
    operand_a <= r.a;
    operand_b <= r.b;
    do @(posedge clk); while (in_stall);
    if (r.typed) exp_r = '{r.dbl, r.word, r.uns};
    else exp_r = alu_predict(r.cmd, r.a, r.b);
    pending_results.push_back(exp_r);
    sent++;
  endtask

  initial begin
    table_rows.push_back(row(CMD_AND, 64'h0, 64'h0, 1, 64'h0, 32'h0, 1'b0));
    table_rows.push_back(row(CMD_NOT, 64'h7FF8000000000000, 64'h0, 1,
                             64'hBFF0000000000000, 32'hFFFFFFFF, 1'b0));
    table_rows.push_back(row(CMD_NOT, 64'h7FF0000000000000, 64'h0, 1,
                             64'hBFF0000000000000, 32'hFFFFFFFF, 1'b0));
    table_rows.push_back(row(CMD_NOT, 64'hFFF0000000000000, 64'h0, 1,
                             64'hBFF0000000000000, 32'hFFFFFFFF, 1'b0));
    table_rows.push_back(row(CMD_NOT, 64'h8000000000000000, 64'h0, 1,
                             64'hBFF0000000000000, 32'hFFFFFFFF, 1'b0));
    table_rows.push_back(row(CMD_NOT, 64'h0000000000000001, 64'h0, 1,
                             64'hBFF0000000000000, 32'hFFFFFFFF, 1'b0));
    table_rows.push_back(row(CMD_NOT, 64'h4530000000000000, 64'h0, 1,
                             64'hBFF0000000000000, 32'hFFFFFFFF, 1'b0));
    table_rows.push_back(row(CMD_SHL, 64'h3FF0000000000000, 64'h4040000000000000, 1,
                             64'h3FF0000000000000, 32'h1, 1'b0));
    table_rows.push_back(row(CMD_NOP, '1, '1, 1, 64'h0, 32'h0, 1'b0));
    table_rows.push_back(row(CMD_SHR, 64'hBFF0000000000000, 64'h0, 1,
                             64'h41EFFFFFFFE00000, 32'hFFFFFFFF, 1'b1));
    table_rows.push_back(row(CMD_SAR, 64'h41E0000000000000, 64'h403F000000000000, 1,
                             64'hBFF0000000000000, 32'hFFFFFFFF, 1'b0));
    table_rows.push_back(row(CMD_OR, 64'h7FEFFFFFFFFFFFFF, 64'h433FFFFFFFFFFFFF));
    table_rows.push_back(row(CMD_XOR, 64'hC1E0000000000000, 64'h41F0000000000000));
    table_rows.push_back(row(CMD_AND, '1, 64'h41EFFFFFFFE00000));
    table_rows.push_back(row(CMD_SHL, 64'h3FF0000000000000, 64'h403F000000000000));
    table_rows.push_back(row(CMD_SHR, 64'hC1E0000000000000, 64'h403F000000000000));
    table_rows.push_back(row(CMD_SAR, 64'hC08F400000000000, 64'h4000000000000000));
    table_rows.push_back(row(CMD_XOR, 64'h3FE0000000000000, 64'hBFE0000000000000));
    table_rows.push_back(row(CMD_OR, 64'h452FFFFFFFFFFFFF, 64'h4330000000000001));
    table_rows.push_back(row(CMD_SHR, 64'h41DFFFFFFFC00000, 64'h0010000000000000));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (table_rows[i]) send(table_rows[i]);
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 150 == 0) quiet = ($urandom_range(0, 2) == 0);
      send(row(cmd_t'($urandom_range(0, 7)), random_operand(), random_operand()));
    end
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d transactions: special operands, all commands, random gaps and stalls.",
             sent);
    $display("Checked %0d results, %0d mismatches.", checked, errors);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    wait (sent >= 300);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    alu_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      checked++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result double=%h word=%h uns=%b", $time,
                 result_double, result_word, result_unsigned);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result_double !== exp_r.dbl) begin
          $display("%0t: result_double expected %h actual %h", $time, exp_r.dbl, result_double);
          errors++;
        end
        if (result_word !== exp_r.word) begin
          $display("%0t: result_word expected %h actual %h", $time, exp_r.word, result_word);
          errors++;
        end
        if (result_unsigned !== exp_r.uns) begin
          $display("%0t: result_unsigned expected %b actual %b", $time, exp_r.uns,
                   result_unsigned);
          errors++;
        end
      end
      out_wait = quiet ? 0 : $urandom_range(0, 17);
    end
    if (hold_off) begin
      out_stall <= 1'b1;
    end else if (out_wait > 0) begin
      out_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

endmodule
`default_nettype wire

### sim.f
hdl/dibw_pkg.sv
hdl/double_int32_wrap_bitwise_alu_core.sv
hdl/dibw_checker.sv
dv/tb_double_int32_wrap_bitwise_alu_core.sv
